[design/bqcd_pkg.sv]
`timescale 1ns / 1ps

package bqcd_pkg;

    localparam int FREQ_W = 17;
    localparam int QV_W   = 16;
    localparam int GAIN_W = 14;
    localparam int FS_W   = 18;
    localparam int COEF_W = 32;

    localparam logic [FS_W-1:0]   FS_MIN   = 18'd8000;
    localparam logic [FS_W-1:0]   FS_MAX   = 18'd192000;
    localparam logic [FS_W-1:0]   FS_RESET = 18'd48000;
    localparam logic [FREQ_W-1:0] F_MIN    = 17'd10;
    localparam logic [QV_W-1:0]   Q_FLOOR  = 16'd41;

    // floor(x / 100) = (x * RECIP100) >> 30 for x up to FS_MAX * FS_NUM
    localparam logic [23:0] FS_NUM    = 24'd49;
    localparam logic [23:0] RECIP100  = 24'd10737419;

    localparam logic signed [43:0] ONE_Q30_W   = 44'sd1073741824;
    localparam logic signed [32:0] ONE_Q30_P   = 33'sd1073741824;
    localparam logic signed [35:0] CORDIC_K    = 36'sd652032874;
    localparam logic signed [42:0] DB_LOG2_Q40 = 43'sd356689313;
    localparam logic signed [59:0] LN2_Q30     = 60'sd744261118;
    localparam logic [31:0]        QUARTER     = 32'h4000_0000;

    localparam int DIV_NUM_W = 43;
    localparam int DIV_DEN_W = 42;
    localparam int DIV_QUO_W = 41;
    localparam int DIV_SH_W  = 6;
    localparam logic [DIV_QUO_W-1:0] DIV_CAP = 41'h100_0000_0000;

    typedef enum logic [1:0] {
        TYPE_LOWPASS,
        TYPE_HIGHPASS,
        TYPE_BANDPASS,
        TYPE_PEAKING
    } filt_type_t;

    typedef struct packed {
        filt_type_t                ftype;
        logic [FREQ_W-1:0]         freq;
        logic [QV_W-1:0]           qv;
        logic signed [GAIN_W-1:0]  gain;
        logic [FS_W-1:0]           fs;
    } job_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } coef_set_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] numer;
        logic [DIV_DEN_W-1:0] denom;
        logic [DIV_SH_W-1:0]  shamt;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_QUO_W-1:0] quot;
    } div_rsp_t;

    // CORDIC step angles, turns in Q32
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            5'd31: v = 32'd0;
        endcase
        return v;
    endfunction

    // ceil(2^35 / k): exact floor division by k for values below 2^31
    function automatic logic [35:0] recip_k(input logic [2:0] k);
        logic [35:0] v;
        unique case (k)
            3'd1:    v = 36'd34359738368;
            3'd2:    v = 36'd17179869184;
            3'd3:    v = 36'd11453246123;
            3'd4:    v = 36'd8589934592;
            3'd5:    v = 36'd6871947674;
            3'd6:    v = 36'd5726623062;
            3'd7:    v = 36'd4908534053;
            default: v = 36'd0;
        endcase
        return v;
    endfunction

endpackage

[design/bqcd_if.sv]
`timescale 1ns / 1ps

interface bqcd_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [16:0]        frequency_hz;
    logic [15:0]        q_value;
    logic signed [13:0] gain_db;

    modport source (output valid, req_type, frequency_hz, q_value, gain_db, input ready);
    modport sink   (input valid, req_type, frequency_hz, q_value, gain_db, output ready);
endinterface

interface bqcd_coef_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] coef_b0;
    logic signed [31:0] coef_b1;
    logic signed [31:0] coef_b2;
    logic signed [31:0] coef_a1;
    logic signed [31:0] coef_a2;

    modport source (output valid, coef_b0, coef_b1, coef_b2, coef_a1, coef_a2, input ready);
    modport sink   (input valid, coef_b0, coef_b1, coef_b2, coef_a1, coef_a2, output ready);
endinterface

[design/bqcd_front.sv]
`timescale 1ns / 1ps

module bqcd_front import bqcd_pkg::*;
(
    bqcd_req_if.sink       req_ch,
    input  logic [FS_W-1:0] fs_cfg,
    input  logic            queue_ready,
    output logic            push,
    output job_t            job
);

    logic [FS_W-1:0] fs_clamped;

    assign req_ch.ready = queue_ready;
    assign push         = req_ch.valid && queue_ready;

    always_comb
    begin
        if (fs_cfg < FS_MIN)
            fs_clamped = FS_MIN;
        else if (fs_cfg > FS_MAX)
            fs_clamped = FS_MAX;
        else
            fs_clamped = fs_cfg;
    end

    // floor the frequency and Q here; the upper frequency bound needs fs * 0.49
    always_comb
    begin
        job.ftype = filt_type_t'(req_ch.req_type);
        job.freq  = (req_ch.frequency_hz < F_MIN) ? F_MIN : req_ch.frequency_hz;
        job.qv    = (req_ch.q_value < Q_FLOOR) ? Q_FLOOR : req_ch.q_value;
        job.gain  = req_ch.gain_db;
        job.fs    = fs_clamped;
    end

endmodule

[design/bqcd_queue.sv]
`timescale 1ns / 1ps

module bqcd_queue import bqcd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic not_full,
    input  logic pop,
    output logic not_empty,
    output job_t head
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

[design/bqcd_divider.sv]
`timescale 1ns / 1ps

module bqcd_divider import bqcd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = 7;

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_QUO_W-1:0] quo_reg;
    logic                 ovf_reg;

    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_diff;
    logic                 fit;

    // one quotient bit per cycle; the numerator runs out into trailing zeros
    assign rem_sh   = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign fit      = (rem_sh >= {1'b0, den_reg});
    assign rem_diff = rem_sh - {1'b0, den_reg};

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = (den_reg == '0 || ovf_reg || quo_reg[DIV_QUO_W-1]) ? DIV_CAP : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIV_NUM_W) + CNT_W'(req.shamt);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.numer;
            den_reg <= req.denom;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_NUM_W-2:0], 1'b0};
            rem_reg <= fit ? rem_diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_QUO_W-2:0], fit};
            // a bit shifted out past the cap keeps the quotient saturated
            ovf_reg <= ovf_reg | quo_reg[DIV_QUO_W-1];
        end
    end

endmodule

[design/bqcd_back.sv]
`timescale 1ns / 1ps

module bqcd_back import bqcd_pkg::*;
#(
    parameter int COEF_FRAC_BITS  = 26,
    parameter int TRIG_ITERATIONS = 24
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_avail,
    input  job_t      job_head,
    output logic      job_pop,
    output div_req_t  div_req,
    input  div_rsp_t  div_rsp,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output coef_set_t rsp_data
);

    localparam int IT_W = $clog2(TRIG_ITERATIONS + 1);

    typedef enum logic [4:0] {
        S_IDLE,
        S_FMAX_MUL,
        S_FMAX_CLAMP,
        S_TURN_GO,
        S_TURN_WAIT,
        S_CORDIC,
        S_ALPHA_GO,
        S_ALPHA_WAIT,
        S_PW_E,
        S_PW_T,
        S_PS_MUL,
        S_PS_DIV,
        S_GAIN,
        S_UM_LO,
        S_UM_HI,
        S_ALD_GO,
        S_ALD_WAIT,
        S_NUMS,
        S_COEF_GO,
        S_COEF_WAIT,
        S_OUT
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [IT_W-1:0]    it_reg;
    logic [2:0]         k_reg;
    logic [2:0]         idx_reg;
    logic               out_vld_reg;

    job_t               job_reg;
    logic [23:0]        prod49_reg;
    logic [FREQ_W-1:0]  freq_reg;
    logic signed [35:0] x_reg;
    logic signed [35:0] y_reg;
    logic signed [33:0] z_reg;
    logic               quarter_reg;
    logic signed [35:0] cw_reg;
    logic [36:0]        al_reg;
    logic signed [42:0] e_reg;
    logic signed [29:0] t_reg;
    logic signed [3:0]  n_reg;
    logic signed [32:0] p_reg;
    logic signed [62:0] tp_reg;
    logic [34:0]        gain_reg;
    logic [36:0]        ulo_reg;
    logic [41:0]        ala_reg;
    logic [40:0]        ald_reg;
    logic signed [43:0] num_reg [5];
    logic [41:0]        a0_reg;
    logic signed [31:0] res_reg [5];
    coef_set_t          out_data_reg;

    logic               out_load;
    logic [47:0]        fmax_prod;
    logic [17:0]        fmax_w;
    logic [31:0]        turn_w;
    logic               quarter_w;
    logic [31:0]        z_start;
    logic [4:0]         it_idx;
    logic signed [35:0] dx;
    logic signed [35:0] dy;
    logic signed [33:0] atan_w;
    logic               cordic_last;
    logic signed [35:0] cw_w;
    logic signed [35:0] sw_w;
    logic [35:0]        sw_pos;
    logic signed [59:0] t_prod;
    logic signed [3:0]  n_w;
    logic signed [32:0] v_w;
    logic [32:0]        v_mag;
    logic [66:0]        kq_prod;
    logic [31:0]        kq_w;
    logic signed [32:0] p_w;
    logic [31:0]        p_u;
    logic [3:0]         n_mag;
    logic [51:0]        ulo_prod;
    logic [56:0]        uhi_sum;
    logic signed [43:0] cw44;
    logic signed [43:0] al44;
    logic signed [43:0] ala44;
    logic signed [43:0] ald44;
    logic signed [43:0] lp_b1;
    logic signed [43:0] hp_sum;
    logic signed [43:0] nb0, nb1, nb2, na1, na2, na0;
    logic signed [43:0] num_sel;
    logic [43:0]        num_mag;
    logic [41:0]        q_round;
    logic signed [31:0] coef_w;

    assign job_pop   = (state_reg == S_IDLE) && job_avail;
    assign out_load  = (state_reg == S_OUT) && (!out_vld_reg || rsp_ready);
    assign rsp_valid = out_vld_reg;
    assign rsp_data  = out_data_reg;

    // frequency ceiling and CORDIC setup
    assign fmax_prod = 48'(prod49_reg) * 48'(RECIP100);
    assign fmax_w    = fmax_prod[47:30];
    assign turn_w    = div_rsp.quot[31:0];
    assign quarter_w = |turn_w[31:30];
    assign z_start   = quarter_w ? (turn_w - QUARTER) : turn_w;

    assign it_idx      = 5'(it_reg);
    assign dx          = y_reg >>> it_idx;
    assign dy          = x_reg >>> it_idx;
    assign atan_w      = $signed({2'b00, atan_turn(it_idx)});
    assign cordic_last = (it_reg == IT_W'(TRIG_ITERATIONS - 1));

    // undo the quarter-turn rotation
    assign cw_w   = quarter_reg ? -y_reg : x_reg;
    assign sw_w   = quarter_reg ? x_reg : y_reg;
    assign sw_pos = sw_w[35] ? '0 : sw_w;

    // 10^(g/40) as 2^n * e^t, t = r * ln2 with r rounded into [-0.5, 0.5)
    assign t_prod = 60'($signed(e_reg[39:10])) * LN2_Q30;
    assign n_w    = 4'($signed(e_reg[42:40])) + $signed({3'b000, e_reg[39]});

    // series term divided by k, truncating toward zero
    assign v_w     = tp_reg[62:30];
    assign v_mag   = v_w[32] ? 33'(-v_w) : 33'(v_w);
    assign kq_prod = 67'(v_mag[30:0]) * 67'(recip_k(k_reg));
    assign kq_w    = kq_prod[66:35];
    assign p_w     = v_w[32] ? (ONE_Q30_P - $signed({1'b0, kq_w}))
                             : (ONE_Q30_P + $signed({1'b0, kq_w}));
    assign p_u     = p_reg[31:0];
    assign n_mag   = n_reg[3] ? 4'(-n_reg) : 4'(n_reg);

    assign ulo_prod = 52'(al_reg) * 52'(gain_reg[14:0]);
    assign uhi_sum  = 57'(al_reg) * 57'(gain_reg[34:15]) + 57'(ulo_reg);

    // numerators of the five coefficients and the shared denominator a0
    assign cw44   = 44'(cw_reg);
    assign al44   = $signed({7'b0, al_reg});
    assign ala44  = $signed({2'b0, ala_reg});
    assign ald44  = $signed({3'b0, ald_reg});
    assign lp_b1  = ONE_Q30_W - cw44;
    assign hp_sum = ONE_Q30_W + cw44;
    assign na1    = -(cw44 <<< 1);

    always_comb
    begin
        na0 = ONE_Q30_W + al44;
        na2 = ONE_Q30_W - al44;
        unique case (job_reg.ftype)
            TYPE_LOWPASS:
            begin
                nb1 = lp_b1;
                nb0 = lp_b1 >>> 1;
                nb2 = lp_b1 >>> 1;
            end
            TYPE_HIGHPASS:
            begin
                nb0 = hp_sum >>> 1;
                nb1 = -hp_sum;
                nb2 = hp_sum >>> 1;
            end
            TYPE_BANDPASS:
            begin
                nb0 = al44;
                nb1 = '0;
                nb2 = -al44;
            end
            TYPE_PEAKING:
            begin
                nb0 = ONE_Q30_W + ala44;
                nb1 = na1;
                nb2 = ONE_Q30_W - ala44;
                na0 = ONE_Q30_W + ald44;
                na2 = ONE_Q30_W - ald44;
            end
        endcase
    end

    // rounding half away from zero, then saturate to 32 bits
    assign num_sel = num_reg[idx_reg];
    assign num_mag = num_sel[43] ? 44'(-num_sel) : 44'(num_sel);
    assign q_round = ({1'b0, div_rsp.quot} + 42'd1) >> 1;

    always_comb
    begin
        if (!num_sel[43])
            coef_w = (q_round > 42'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q_round[31:0]);
        else
            coef_w = (q_round > 42'h0_8000_0000) ? 32'sh8000_0000 : $signed(-q_round[31:0]);
    end

    always_comb
    begin
        div_req = '0;
        unique case (state_reg)
            S_TURN_GO:
            begin
                div_req.start = 1'b1;
                div_req.numer = DIV_NUM_W'(freq_reg);
                div_req.shamt = DIV_SH_W'(32);
                div_req.denom = DIV_DEN_W'(job_reg.fs);
            end
            S_ALPHA_GO:
            begin
                div_req.start = 1'b1;
                div_req.numer = DIV_NUM_W'(sw_pos);
                div_req.shamt = DIV_SH_W'(11);
                div_req.denom = DIV_DEN_W'(job_reg.qv);
            end
            S_ALD_GO:
            begin
                div_req.start = 1'b1;
                div_req.numer = DIV_NUM_W'(al_reg);
                div_req.shamt = DIV_SH_W'(30);
                div_req.denom = DIV_DEN_W'(gain_reg);
            end
            S_COEF_GO:
            begin
                div_req.start = 1'b1;
                div_req.numer = num_mag[DIV_NUM_W-1:0];
                div_req.shamt = DIV_SH_W'(COEF_FRAC_BITS + 1);
                div_req.denom = a0_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:       if (job_avail) state_next = S_FMAX_MUL;
            S_FMAX_MUL:   state_next = S_FMAX_CLAMP;
            S_FMAX_CLAMP: state_next = S_TURN_GO;
            S_TURN_GO:    state_next = S_TURN_WAIT;
            S_TURN_WAIT:  if (div_rsp.done) state_next = S_CORDIC;
            S_CORDIC:     if (cordic_last) state_next = S_ALPHA_GO;
            S_ALPHA_GO:   state_next = S_ALPHA_WAIT;
            S_ALPHA_WAIT:
            begin
                if (div_rsp.done)
                    state_next = (job_reg.ftype == TYPE_PEAKING) ? S_PW_E : S_NUMS;
            end
            S_PW_E:       state_next = S_PW_T;
            S_PW_T:       state_next = S_PS_MUL;
            S_PS_MUL:     state_next = S_PS_DIV;
            S_PS_DIV:     state_next = (k_reg == 3'd1) ? S_GAIN : S_PS_MUL;
            S_GAIN:       state_next = S_UM_LO;
            S_UM_LO:      state_next = S_UM_HI;
            S_UM_HI:      state_next = S_ALD_GO;
            S_ALD_GO:     state_next = S_ALD_WAIT;
            S_ALD_WAIT:   if (div_rsp.done) state_next = S_NUMS;
            S_NUMS:       state_next = S_COEF_GO;
            S_COEF_GO:    state_next = S_COEF_WAIT;
            S_COEF_WAIT:
            begin
                if (div_rsp.done)
                    state_next = (idx_reg == 3'd4) ? S_OUT : S_COEF_GO;
            end
            S_OUT:        if (out_load) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            it_reg      <= '0;
            k_reg       <= 3'd7;
            idx_reg     <= 3'd0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_TURN_WAIT)
                it_reg <= '0;
            else if (state_reg == S_CORDIC)
                it_reg <= it_reg + IT_W'(1);
            if (state_reg == S_PW_T)
                k_reg <= 3'd7;
            else if (state_reg == S_PS_DIV)
                k_reg <= k_reg - 3'd1;
            if (state_reg == S_NUMS)
                idx_reg <= 3'd0;
            else if (state_reg == S_COEF_WAIT && div_rsp.done)
                idx_reg <= idx_reg + 3'd1;
            if (out_load)
                out_vld_reg <= 1'b1;
            else if (rsp_ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (job_avail) job_reg <= job_head;
            S_FMAX_MUL:
                prod49_reg <= 24'(job_reg.fs) * FS_NUM;
            S_FMAX_CLAMP:
                freq_reg <= (18'(job_reg.freq) > fmax_w) ? fmax_w[FREQ_W-1:0] : job_reg.freq;
            S_TURN_WAIT:
            begin
                if (div_rsp.done)
                begin
                    x_reg       <= CORDIC_K;
                    y_reg       <= '0;
                    z_reg       <= $signed({2'b00, z_start});
                    quarter_reg <= quarter_w;
                end
            end
            S_CORDIC:
            begin
                if (!z_reg[33])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_w;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_w;
                end
            end
            S_ALPHA_GO:
                cw_reg <= cw_w;
            S_ALPHA_WAIT:
                if (div_rsp.done) al_reg <= div_rsp.quot[36:0];
            S_PW_E:
                e_reg <= 43'(job_reg.gain) * DB_LOG2_Q40;
            S_PW_T:
            begin
                t_reg <= t_prod[59:30];
                n_reg <= n_w;
                p_reg <= ONE_Q30_P;
            end
            S_PS_MUL:
                tp_reg <= 63'(t_reg) * 63'(p_reg);
            S_PS_DIV:
                p_reg <= p_w;
            S_GAIN:
                gain_reg <= n_reg[3] ? (35'(p_u) >> n_mag[2:0]) : (35'(p_u) << n_mag[2:0]);
            S_UM_LO:
                ulo_reg <= ulo_prod[51:15];
            S_UM_HI:
                ala_reg <= uhi_sum[56:15];
            S_ALD_WAIT:
                if (div_rsp.done) ald_reg <= div_rsp.quot;
            S_NUMS:
            begin
                num_reg[0] <= nb0;
                num_reg[1] <= nb1;
                num_reg[2] <= nb2;
                num_reg[3] <= na1;
                num_reg[4] <= na2;
                a0_reg     <= na0[41:0];
            end
            S_COEF_WAIT:
                if (div_rsp.done) res_reg[idx_reg] <= coef_w;
            S_OUT:
            begin
                if (out_load)
                begin
                    out_data_reg.b0 <= res_reg[0];
                    out_data_reg.b1 <= res_reg[1];
                    out_data_reg.b2 <= res_reg[2];
                    out_data_reg.a1 <= res_reg[3];
                    out_data_reg.a2 <= res_reg[4];
                end
            end
            default: ;
        endcase
    end

endmodule

[design/biquad_coefficient_designer.sv]
`timescale 1ns / 1ps
// Audio EQ biquad coefficient designer.
// req_ch takes one word per request: filter type, frequency in Hz, Q (Q4.12)
// and gain in dB (signed Q6.8). coef_ch returns one word per request with
// b0, b1, b2, a1, a2 normalised by a0, signed Q6.26, saturated.
// sample_rate_we/sample_rate_wdata write the sample rate; write it only
// while no request is in flight.
// A two-entry queue sits behind the input, so up to two requests are taken
// while one is being worked on, and the finished word sits in an output
// register while the next request is computed.
// The back end works on one request at a time. Nearly all of its time is
// spent in the shared bit-serial divider, one quotient bit per cycle, with
// seven divisions per request and eight for peaking.
// CORDIC runs TRIG_ITERATIONS iterations.
// Reset empties the queue and the output register and sets the sample rate
// to 48000 Hz. A stalled receiver holds the word and the back end with it;
// once the queue holds two requests, req_ch.ready drops.

module biquad_coefficient_designer import bqcd_pkg::*;
#(
    parameter int COEF_FRAC_BITS  = 26,
    parameter int TRIG_ITERATIONS = 24
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sample_rate_we,
    input  logic [FS_W-1:0] sample_rate_wdata,
    bqcd_req_if.sink        req_ch,
    bqcd_coef_if.source     coef_ch
);

    logic [FS_W-1:0] sample_rate_reg;
    logic            push;
    job_t            push_job;
    logic            q_not_full;
    logic            q_not_empty;
    logic            pop;
    job_t            head;
    div_req_t        div_req;
    div_rsp_t        div_rsp;
    logic            rsp_valid;
    logic            rsp_ready;
    coef_set_t       rsp_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_rate_reg <= FS_RESET;
        else if (sample_rate_we)
            sample_rate_reg <= sample_rate_wdata;
    end

    bqcd_front u_front (
        .req_ch      (req_ch),
        .fs_cfg      (sample_rate_reg),
        .queue_ready (q_not_full),
        .push        (push),
        .job         (push_job)
    );

    bqcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .not_full  (q_not_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (head)
    );

    bqcd_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    bqcd_back #(
        .COEF_FRAC_BITS  (COEF_FRAC_BITS),
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (q_not_empty),
        .job_head  (head),
        .job_pop   (pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    assign coef_ch.valid   = rsp_valid;
    assign coef_ch.coef_b0 = rsp_data.b0;
    assign coef_ch.coef_b1 = rsp_data.b1;
    assign coef_ch.coef_b2 = rsp_data.b2;
    assign coef_ch.coef_a1 = rsp_data.a1;
    assign coef_ch.coef_a2 = rsp_data.a2;
    assign rsp_ready       = coef_ch.ready;

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> q_not_empty)
        else $error("accepted request did not reach the queue");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_not_empty)
        else $error("back end popped an empty queue");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

endmodule
